// ----- design/command_word_receiver_unit_macros.svh -----
// Assertion macros for the command word receiver checker.
`ifndef COMMAND_WORD_RECEIVER_UNIT_MACROS_SVH
`define COMMAND_WORD_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CWR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cwr check failed");

// Next-cycle implication, checked out of reset.
`define CWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cwr check failed");

`endif

// ----- design/cwr_pkg.sv -----
// Package: codes, constants and result type of the command word receiver.
`default_nettype none
package cwr_pkg;

  // Table capture length, header counted as word 0
  localparam int unsigned TABLE_WORDS = 84;
  localparam int unsigned TABLE_IDX_W = 7;
  localparam logic [TABLE_IDX_W-1:0] TABLE_LAST = TABLE_IDX_W'(TABLE_WORDS);

  // Single-word codes
  localparam logic [15:0] CMD_TEST1      = 16'h9901;
  localparam logic [15:0] CMD_TEST2      = 16'h9902;
  localparam logic [15:0] CMD_TEST3      = 16'h994E;
  localparam logic [15:0] CMD_TABLE_HDR  = 16'h9931;
  localparam logic [15:0] CMD_COLL_A     = 16'h9910;
  localparam logic [15:0] CMD_COLL_B     = 16'h9911;
  localparam logic [15:0] CMD_ORDER10    = 16'h9921;
  localparam logic [15:0] CMD_ORDER2     = 16'h9942;
  localparam logic [15:0] CMD_ORDER3     = 16'h9943;
  localparam logic [15:0] CMD_ORDER5     = 16'h9945;
  localparam logic [15:0] CMD_ORDER6     = 16'h9946;
  localparam logic [15:0] CMD_ORDER7     = 16'h9922;
  localparam logic [15:0] CMD_ORDER8     = 16'h9923;
  localparam logic [15:0] CMD_ORDER13    = 16'h9924;
  localparam logic [15:0] CMD_MOD_LONG   = 16'h995A;

  // Upper 12 bits that open a modify capture
  localparam logic [11:0] MOD_HI_A = 12'h995;
  localparam logic [11:0] MOD_HI_B = 12'h996;
  localparam logic [11:0] MOD_HI_C = 12'h999;
  localparam logic [11:0] MOD_HI_D = 12'h99A;

  localparam logic [1:0] MOD_LEN_SHORT = 2'd2;
  localparam logic [1:0] MOD_LEN_LONG  = 2'd3;

  // Test codes
  localparam logic [2:0] TEST_NONE       = 3'd0;
  localparam logic [2:0] TEST_ONE        = 3'd1;
  localparam logic [2:0] TEST_TWO        = 3'd2;
  localparam logic [2:0] TEST_THREE      = 3'd3;
  localparam logic [2:0] TEST_TABLE_DONE = 3'd4;

  // Order codes
  localparam logic [3:0] ORDER_NONE       = 4'd0;
  localparam logic [3:0] ORDER_2          = 4'd2;
  localparam logic [3:0] ORDER_3          = 4'd3;
  localparam logic [3:0] ORDER_5          = 4'd5;
  localparam logic [3:0] ORDER_6          = 4'd6;
  localparam logic [3:0] ORDER_7          = 4'd7;
  localparam logic [3:0] ORDER_8          = 4'd8;
  localparam logic [3:0] ORDER_TABLE_DONE = 4'd9;
  localparam logic [3:0] ORDER_10         = 4'd10;
  localparam logic [3:0] ORDER_MOD_DONE   = 4'd11;
  localparam logic [3:0] ORDER_13         = 4'd13;

  typedef struct packed {
    logic [2:0]             test_code;
    logic [3:0]             order_code;
    logic                   collection_start;
    logic                   table_write;
    logic [TABLE_IDX_W-1:0] table_index;
    logic                   table_complete;
    logic                   modify_write;
    logic [1:0]             modify_index;
    logic [15:0]            stored_word;
  } cwr_result_t;

  // Map a single-word order command to its order number
  function automatic logic [3:0] single_order(input logic [15:0] w);
    logic [3:0] ord;
    case (w)
      CMD_ORDER10: ord = ORDER_10;
      CMD_ORDER2:  ord = ORDER_2;
      CMD_ORDER3:  ord = ORDER_3;
      CMD_ORDER5:  ord = ORDER_5;
      CMD_ORDER6:  ord = ORDER_6;
      CMD_ORDER7:  ord = ORDER_7;
      CMD_ORDER8:  ord = ORDER_8;
      CMD_ORDER13: ord = ORDER_13;
      default:     ord = ORDER_NONE;
    endcase
    return ord;
  endfunction

endpackage
`default_nettype wire

// ----- design/cwr_in_stage.sv -----
// Input register stage: captures one received word per transaction.
`default_nettype none
module cwr_in_stage
  import cwr_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [15:0] word_i,
  input  wire         out_ready_i,
  output logic        s1_valid_o,
  output logic        s1_adv_o,
  output logic [15:0] s1_word_o
);

  logic        valid_q, valid_d;
  logic [15:0] word_q;
  logic        accept;

  // Advance when the result register can take the item
  assign s1_adv_o   = valid_q && out_ready_i;
  assign in_stall_o = valid_q && !out_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (s1_adv_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_word_o  = word_q;

endmodule
`default_nettype wire

// ----- design/cwr_decode.sv -----
// Priority decoder with table and modify capture state.
`default_nettype none
module cwr_decode
  import cwr_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         adv_i,
  input  wire  [15:0] word_i,
  output cwr_result_t res_o
);

  logic                   tbl_act_q, tbl_act_d;
  logic [TABLE_IDX_W-1:0] tbl_cnt_q, tbl_cnt_d;
  logic                   mod_act_q, mod_act_d;
  logic [1:0]             mod_cnt_q, mod_cnt_d;
  logic [1:0]             mod_len_q, mod_len_d;
  logic [TABLE_IDX_W-1:0] tbl_inc;
  logic [1:0]             mod_inc;
  logic [3:0]             ord_single;
  logic                   mod_open;

  assign tbl_inc    = tbl_cnt_q + TABLE_IDX_W'(1);
  assign mod_inc    = mod_cnt_q + 2'd1;
  assign ord_single = single_order(word_i);
  assign mod_open   = word_i[15:4] inside {MOD_HI_A, MOD_HI_B, MOD_HI_C, MOD_HI_D};

  // Decode in priority order and compute next capture state
  always_comb begin
    res_o     = '0;
    tbl_act_d = tbl_act_q;
    tbl_cnt_d = tbl_cnt_q;
    mod_act_d = mod_act_q;
    mod_cnt_d = mod_cnt_q;
    mod_len_d = mod_len_q;
    if (word_i == CMD_TEST1) begin
      res_o.test_code = TEST_ONE;
    end else if (word_i == CMD_TEST2) begin
      res_o.test_code = TEST_TWO;
    end else if (word_i == CMD_TEST3) begin
      res_o.test_code = TEST_THREE;
    end else if (word_i == CMD_TABLE_HDR || tbl_act_q) begin
      res_o.table_write = 1'b1;
      res_o.table_index = tbl_cnt_q;
      res_o.stored_word = word_i;
      tbl_act_d         = 1'b1;
      tbl_cnt_d         = tbl_inc;
      if (tbl_inc == TABLE_LAST) begin
        tbl_act_d            = 1'b0;
        tbl_cnt_d            = '0;
        res_o.table_complete = 1'b1;
        res_o.order_code     = ORDER_TABLE_DONE;
        res_o.test_code      = TEST_TABLE_DONE;
      end
    end else if (word_i == CMD_COLL_A || word_i == CMD_COLL_B) begin
      res_o.collection_start = 1'b1;
    end else if (ord_single != ORDER_NONE) begin
      res_o.order_code = ord_single;
    end else if (mod_act_q || mod_open) begin
      res_o.modify_write = 1'b1;
      res_o.modify_index = mod_cnt_q;
      res_o.stored_word  = word_i;
      mod_cnt_d          = mod_inc;
      if (!mod_act_q) begin
        mod_act_d = 1'b1;
        mod_len_d = (word_i == CMD_MOD_LONG) ? MOD_LEN_LONG : MOD_LEN_SHORT;
      end else if (mod_inc >= mod_len_q) begin
        res_o.order_code = ORDER_MOD_DONE;
        mod_act_d        = 1'b0;
        mod_cnt_d        = '0;
      end
    end
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_act_q <= 1'b0;
      tbl_cnt_q <= '0;
      mod_act_q <= 1'b0;
      mod_cnt_q <= '0;
      mod_len_q <= '0;
    end else if (adv_i) begin
      tbl_act_q <= tbl_act_d;
      tbl_cnt_q <= tbl_cnt_d;
      mod_act_q <= mod_act_d;
      mod_cnt_q <= mod_cnt_d;
      mod_len_q <= mod_len_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/cwr_out_stage.sv -----
// Result register stage: holds one decoded result until taken.
`default_nettype none
module cwr_out_stage
  import cwr_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         load_i,
  input  cwr_result_t res_i,
  input  wire         out_stall_i,
  output logic        out_valid_o,
  output logic        ready_o,
  output cwr_result_t res_o
);

  logic        valid_q, valid_d;
  cwr_result_t res_q;

  // Free when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ----- design/command_word_receiver_unit.sv -----
// Top level of the command word receiver.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | word_i
//   out     | output    | out_valid_o/out_stall_i | test_code_o .. stored_word_o
//
// One word per cycle sustained while out_stall_i is low; an accepted word is
// held in the input register, then decoded and loaded into the result register.
// Capture state is committed as an item moves into the result register.
// Reset (rst_ni low) clears both stage valids and all capture state at once.
// A stalled output holds its result; the input still takes a word until the
// input register also fills, then in_stall_o rises.
`default_nettype none
module command_word_receiver_unit
  import cwr_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  [15:0]            word_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [2:0]             test_code_o,
  output logic [3:0]             order_code_o,
  output logic                   collection_start_o,
  output logic                   table_write_o,
  output logic [TABLE_IDX_W-1:0] table_index_o,
  output logic                   table_complete_o,
  output logic                   modify_write_o,
  output logic [1:0]             modify_index_o,
  output logic [15:0]            stored_word_o
);

  logic        s1_valid;
  logic        s1_adv;
  logic [15:0] s1_word;
  logic        out_ready;
  cwr_result_t dec_res;
  cwr_result_t out_res;

  cwr_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .word_i      (word_i),
    .out_ready_i (out_ready),
    .s1_valid_o  (s1_valid),
    .s1_adv_o    (s1_adv),
    .s1_word_o   (s1_word)
  );

  cwr_decode u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv && s1_valid),
    .word_i (s1_word),
    .res_o  (dec_res)
  );

  cwr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv),
    .res_i       (dec_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .ready_o     (out_ready),
    .res_o       (out_res)
  );

  // Break out the result fields
  assign test_code_o        = out_res.test_code;
  assign order_code_o       = out_res.order_code;
  assign collection_start_o = out_res.collection_start;
  assign table_write_o      = out_res.table_write;
  assign table_index_o      = out_res.table_index;
  assign table_complete_o   = out_res.table_complete;
  assign modify_write_o     = out_res.modify_write;
  assign modify_index_o     = out_res.modify_index;
  assign stored_word_o      = out_res.stored_word;

endmodule
`default_nettype wire

// ----- design/cwr_checker.sv -----
// Port-level checker for the command word receiver, bound to the top level.
`default_nettype none
`include "command_word_receiver_unit_macros.svh"
module cwr_checker
  import cwr_pkg::*;
(
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   out_valid_o,
  input wire                   out_stall_i,
  input wire [2:0]             test_code_o,
  input wire [3:0]             order_code_o,
  input wire                   collection_start_o,
  input wire                   table_write_o,
  input wire [TABLE_IDX_W-1:0] table_index_o,
  input wire                   table_complete_o,
  input wire                   modify_write_o,
  input wire [15:0]            stored_word_o
);

  logic tbl_done_ok;

  // Completion comes only with a table write of the last index and its codes
  assign tbl_done_ok = table_write_o && (table_index_o == TABLE_LAST - TABLE_IDX_W'(1)) &&
                       (test_code_o == TEST_TABLE_DONE) &&
                       (order_code_o == ORDER_TABLE_DONE);
  `CWR_ASSERT_NOW(a_tbl_done, clk_i, rst_ni, out_valid_o && table_complete_o, tbl_done_ok)

  // A word goes to at most one store
  `CWR_ASSERT_NOW(a_one_store, clk_i, rst_ni, out_valid_o, !(table_write_o && modify_write_o))

  // Unstored words show no data
  `CWR_ASSERT_NOW(a_no_data, clk_i, rst_ni, out_valid_o && !table_write_o && !modify_write_o, stored_word_o == 16'h0000)

  // A stalled result holds
  `CWR_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(stored_word_o) && $stable(order_code_o) && $stable(collection_start_o))

endmodule

bind command_word_receiver_unit cwr_checker u_cwr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .test_code_o        (test_code_o),
  .order_code_o       (order_code_o),
  .collection_start_o (collection_start_o),
  .table_write_o      (table_write_o),
  .table_index_o      (table_index_o),
  .table_complete_o   (table_complete_o),
  .modify_write_o     (modify_write_o),
  .stored_word_o      (stored_word_o)
);
`default_nettype wire
